// ===== design/epoch_to_calendar_date_macros.svh =====
// assertion macros shared by the calendar date design
`ifndef EPOCH_TO_CALENDAR_DATE_MACROS_SVH
`define EPOCH_TO_CALENDAR_DATE_MACROS_SVH

`ifndef SYNTHESIS

`define E2C_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("e2c check failed");

`define E2C_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("e2c check failed");

`else

`define E2C_ASSERT_NOW(lbl, ante, cons)

`define E2C_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ===== design/e2c_pkg.sv =====
package e2c_pkg;

  localparam int EpochW   = 31;
  localparam int DivW     = 32;
  localparam int DivSteps = 3;
  localparam int DivCntW  = $clog2(DivSteps);
  localparam int RemW     = 6;
  localparam int DaysW    = 15;
  localparam int YearW    = 11;
  localparam int MonW     = 4;
  localparam int DayW     = 5;
  localparam int LenW     = 9;

  localparam logic [DivCntW-1:0] DivLastStep = DivCntW'(DivSteps - 1);
  localparam logic [RemW-1:0]    SecPerMin   = 6'd60;
  localparam logic [RemW-1:0]    MinPerHour  = 6'd60;
  localparam logic [RemW-1:0]    HrPerDay    = 6'd24;
  localparam logic [RemW-1:0]    DaysPerWeek = 6'd7;
  localparam logic [DivW-1:0]    BaseWeekday = 32'd4;
  localparam logic [YearW-1:0]   BaseYear    = 11'd1970;
  localparam logic [6:0]         Y100Base    = 7'd70;
  localparam logic [6:0]         Y100Last    = 7'd99;
  localparam logic [8:0]         Y400Base    = 9'd370;
  localparam logic [8:0]         Y400Last    = 9'd399;
  localparam logic [LenW-1:0]    YearDays    = 9'd365;
  localparam logic [LenW-1:0]    LeapDays    = 9'd366;
  localparam logic [MonW-1:0]    MonJan      = 4'd0;
  localparam logic [MonW-1:0]    MonFeb      = 4'd1;
  localparam logic [MonW-1:0]    MonDec      = 4'd11;

  // reciprocals and shifts for exact division by 60, 24 and 7
  localparam logic [DivW-1:0]    RecipMin    = 32'h8888_8889;
  localparam logic [DivW-1:0]    RecipDay    = 32'hAAAA_AAAB;
  localparam logic [DivW-1:0]    RecipWeek   = 32'h9249_2493;
  localparam int                 ShiftMin    = 37;
  localparam int                 ShiftDay    = 36;
  localparam int                 ShiftWeek   = 34;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEC,
    ST_MIN,
    ST_HR,
    ST_WDAY,
    ST_CAL
  } e2c_state_t;

  typedef enum logic [1:0] {
    CAL_IDLE,
    CAL_YEAR,
    CAL_MONTH
  } e2c_cal_state_t;

  typedef struct packed {
    logic            done;
    logic [DivW-1:0] quot;
    logic [RemW-1:0] rem;
  } e2c_div_res_t;

  typedef struct packed {
    logic             done;
    logic [DayW-1:0]  day;
    logic [MonW-1:0]  month;
    logic [YearW-1:0] year;
  } e2c_cal_res_t;

  function automatic logic [DayW-1:0] e2c_month_len(input logic [MonW-1:0] mon,
                                                    input logic leap);
    logic [DayW-1:0] len;
    unique case (mon)
      4'd1:                len = leap ? 5'd29 : 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10: len = 5'd30;
      default:             len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

// ===== design/e2c_div.sv =====
`include "epoch_to_calendar_date_macros.svh"

module e2c_div (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [e2c_pkg::DivW-1:0]         dividend,
  input  logic [e2c_pkg::RemW-1:0]         divisor,
  output e2c_pkg::e2c_div_res_t            res
);

  logic                          busy;
  logic                          done;
  logic [e2c_pkg::DivCntW-1:0]   cnt;
  logic [e2c_pkg::DivW-1:0]      num;
  logic [e2c_pkg::RemW-1:0]      dvsr;
  logic [2*e2c_pkg::DivW-1:0]    prod;
  logic [e2c_pkg::DivW-1:0]      quot;
  logic [e2c_pkg::RemW-1:0]      rem;

  logic [e2c_pkg::DivW-1:0]      recip;
  logic [e2c_pkg::DivW-1:0]      quot_next;
  logic [e2c_pkg::RemW-1:0]      rem_next;

  // multiply by the reciprocal, shift, then take the remainder from the low bits
  always_comb begin
    unique case (dvsr)
      e2c_pkg::HrPerDay: begin
        recip     = e2c_pkg::RecipDay;
        quot_next = e2c_pkg::DivW'(prod >> e2c_pkg::ShiftDay);
      end
      e2c_pkg::DaysPerWeek: begin
        recip     = e2c_pkg::RecipWeek;
        quot_next = e2c_pkg::DivW'(prod >> e2c_pkg::ShiftWeek);
      end
      default: begin
        recip     = e2c_pkg::RecipMin;
        quot_next = e2c_pkg::DivW'(prod >> e2c_pkg::ShiftMin);
      end
    endcase
    rem_next = num[e2c_pkg::RemW-1:0] - e2c_pkg::RemW'(quot[e2c_pkg::RemW-1:0] * dvsr);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == e2c_pkg::DivLastStep) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // three-stage pipe (product, quotient, remainder), filled while the divider is busy
  always_ff @(posedge clk) begin
    if (start) begin
      num  <= dividend;
      dvsr <= divisor;
    end else if (busy) begin
      prod <= {{e2c_pkg::DivW{1'b0}}, num} * {{e2c_pkg::DivW{1'b0}}, recip};
      quot <= quot_next;
      rem  <= rem_next;
    end
  end

  assign res.done = done;
  assign res.quot = quot;
  assign res.rem  = rem;

  `E2C_ASSERT_NOW(a_div_rem_below, done, rem < dvsr)
  `E2C_ASSERT_NOW(a_div_no_restart, start, !busy)
  `E2C_ASSERT_NEXT(a_div_done_pulse, done, !done)

endmodule

// ===== design/e2c_cal.sv =====
`include "epoch_to_calendar_date_macros.svh"

module e2c_cal (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [e2c_pkg::DaysW-1:0]    days,
  output e2c_pkg::e2c_cal_res_t        res
);

  e2c_pkg::e2c_cal_state_t phase;
  e2c_pkg::e2c_cal_state_t phase_next;
  logic                        fin;
  logic [e2c_pkg::DaysW-1:0]   days_left;
  logic [e2c_pkg::YearW-1:0]   year;
  logic [6:0]                  y100;
  logic [8:0]                  y400;
  logic [e2c_pkg::MonW-1:0]    mon;

  logic                        leap;
  logic [e2c_pkg::LenW-1:0]    len;
  logic [e2c_pkg::DaysW:0]     diff;
  logic                        fits;
  logic                        year_step;
  logic                        mon_step;
  logic                        walk_end;

  // shared compare and subtract
  always_comb begin
    leap = (year[1:0] == 2'b00) && ((y100 != 7'd0) || (y400 == 9'd0));
    if (phase == e2c_pkg::CAL_YEAR) begin
      len = leap ? e2c_pkg::LeapDays : e2c_pkg::YearDays;
    end else begin
      len = {4'b0, e2c_pkg::e2c_month_len(mon, leap)};
    end
    diff = {1'b0, days_left} - {{(e2c_pkg::DaysW + 1 - e2c_pkg::LenW){1'b0}}, len};
    fits = diff[e2c_pkg::DaysW];
  end

  always_comb begin
    phase_next = phase;
    unique case (phase)
      e2c_pkg::CAL_IDLE:  if (start) phase_next = e2c_pkg::CAL_YEAR;
      e2c_pkg::CAL_YEAR:  if (fits) phase_next = e2c_pkg::CAL_MONTH;
      e2c_pkg::CAL_MONTH: if (fits || mon == e2c_pkg::MonDec) phase_next = e2c_pkg::CAL_IDLE;
      default:            phase_next = e2c_pkg::CAL_IDLE;
    endcase
  end

  always_comb begin
    year_step = 1'b0;
    mon_step  = 1'b0;
    walk_end  = 1'b0;
    unique case (phase)
      e2c_pkg::CAL_IDLE: ;
      e2c_pkg::CAL_YEAR: year_step = !fits;
      e2c_pkg::CAL_MONTH: begin
        mon_step = !fits && (mon != e2c_pkg::MonDec);
        walk_end = !mon_step;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= e2c_pkg::CAL_IDLE;
      fin   <= 1'b0;
    end else begin
      phase <= phase_next;
      if (start) begin
        fin <= 1'b0;
      end else if (walk_end) begin
        fin <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      days_left <= days;
      year      <= e2c_pkg::BaseYear;
      y100      <= e2c_pkg::Y100Base;
      y400      <= e2c_pkg::Y400Base;
      mon       <= e2c_pkg::MonJan;
    end else if (year_step) begin
      days_left <= diff[e2c_pkg::DaysW-1:0];
      year      <= year + 1'b1;
      y100      <= (y100 == e2c_pkg::Y100Last) ? 7'd0 : y100 + 1'b1;
      y400      <= (y400 == e2c_pkg::Y400Last) ? 9'd0 : y400 + 1'b1;
    end else if (mon_step) begin
      days_left <= diff[e2c_pkg::DaysW-1:0];
      mon       <= mon + 1'b1;
    end
  end

  assign res.done  = fin;
  assign res.day   = days_left[e2c_pkg::DayW-1:0] + 1'b1;
  assign res.month = mon + 1'b1;
  assign res.year  = year;

  `E2C_ASSERT_NOW(a_cal_start_idle, start, phase == e2c_pkg::CAL_IDLE)
  `E2C_ASSERT_NOW(a_cal_fin_idle, fin, phase == e2c_pkg::CAL_IDLE)
  `E2C_ASSERT_NOW(a_cal_mon_range, phase == e2c_pkg::CAL_MONTH, mon <= e2c_pkg::MonDec)
  `E2C_ASSERT_NOW(a_cal_day_fits, phase == e2c_pkg::CAL_MONTH && fits, days_left < 15'd31)

endmodule

// ===== design/epoch_to_calendar_date.sv =====
// channel   valid      stall      payload
// request   req_valid  req_stall  epoch_seconds
// result    res_valid  res_stall  day_of_month month_number year_full hour_of_day
//                                 minute_of_hour second_of_minute weekday
//
// one request makes three passes of the shared reciprocal divider (multiply, shift,
// remainder), then the year and month walk of one compare-subtract unit (up to 69
// year and 12 month compares) beside the weekday pass
// a new request is taken once the result is loaded, while that result may still wait
// synchronous active-high reset clears the sequencer and the result valid
`include "epoch_to_calendar_date_macros.svh"

module epoch_to_calendar_date (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            req_valid,
  output logic                            req_stall,
  input  logic [e2c_pkg::EpochW-1:0]      epoch_seconds,
  output logic                            res_valid,
  input  logic                            res_stall,
  output logic [4:0]                      day_of_month,
  output logic [3:0]                      month_number,
  output logic [10:0]                     year_full,
  output logic [4:0]                      hour_of_day,
  output logic [5:0]                      minute_of_hour,
  output logic [5:0]                      second_of_minute,
  output logic [2:0]                      weekday
);

  e2c_pkg::e2c_state_t state;
  e2c_pkg::e2c_state_t state_next;

  e2c_pkg::e2c_div_res_t       div_res;
  e2c_pkg::e2c_cal_res_t       cal_res;
  logic                        div_start;
  logic [e2c_pkg::DivW-1:0]    div_dividend;
  logic [e2c_pkg::RemW-1:0]    div_divisor;
  logic                        cal_start;
  logic                        res_load;

  logic [5:0] sec;
  logic [5:0] min;
  logic [4:0] hr;
  logic [2:0] wday;

  e2c_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .res      (div_res)
  );

  e2c_cal u_cal (
    .clk   (clk),
    .rst   (rst),
    .start (cal_start),
    .days  (div_res.quot[e2c_pkg::DaysW-1:0]),
    .res   (cal_res)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      e2c_pkg::ST_IDLE: if (req_valid) state_next = e2c_pkg::ST_SEC;
      e2c_pkg::ST_SEC:  if (div_res.done) state_next = e2c_pkg::ST_MIN;
      e2c_pkg::ST_MIN:  if (div_res.done) state_next = e2c_pkg::ST_HR;
      e2c_pkg::ST_HR:   if (div_res.done) state_next = e2c_pkg::ST_WDAY;
      e2c_pkg::ST_WDAY: if (div_res.done) state_next = e2c_pkg::ST_CAL;
      e2c_pkg::ST_CAL: begin
        if (cal_res.done && (!res_valid || !res_stall)) state_next = e2c_pkg::ST_IDLE;
      end
      default: state_next = e2c_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    req_stall    = 1'b1;
    div_start    = 1'b0;
    div_dividend = div_res.quot;
    div_divisor  = e2c_pkg::SecPerMin;
    cal_start    = 1'b0;
    res_load     = 1'b0;
    unique case (state)
      e2c_pkg::ST_IDLE: begin
        req_stall    = 1'b0;
        div_start    = req_valid;
        div_dividend = {1'b0, epoch_seconds};
      end
      e2c_pkg::ST_SEC: begin
        div_start   = div_res.done;
        div_divisor = e2c_pkg::MinPerHour;
      end
      e2c_pkg::ST_MIN: begin
        div_start   = div_res.done;
        div_divisor = e2c_pkg::HrPerDay;
      end
      e2c_pkg::ST_HR: begin
        div_start    = div_res.done;
        div_dividend = div_res.quot + e2c_pkg::BaseWeekday;
        div_divisor  = e2c_pkg::DaysPerWeek;
        cal_start    = div_res.done;
      end
      e2c_pkg::ST_WDAY: ;
      e2c_pkg::ST_CAL: res_load = cal_res.done && (!res_valid || !res_stall);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= e2c_pkg::ST_IDLE;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  // partial results of the division passes
  always_ff @(posedge clk) begin
    if (div_res.done) begin
      unique case (state)
        e2c_pkg::ST_SEC:  sec  <= div_res.rem;
        e2c_pkg::ST_MIN:  min  <= div_res.rem;
        e2c_pkg::ST_HR:   hr   <= div_res.rem[4:0];
        e2c_pkg::ST_WDAY: wday <= div_res.rem[2:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      day_of_month     <= cal_res.day;
      month_number     <= cal_res.month;
      year_full        <= cal_res.year;
      hour_of_day      <= hr;
      minute_of_hour   <= min;
      second_of_minute <= sec;
      weekday          <= wday;
    end
  end

  `E2C_ASSERT_NEXT(a_accept_to_sec, req_valid && !req_stall, state == e2c_pkg::ST_SEC)
  `E2C_ASSERT_NOW(a_div_done_state, div_res.done,
    state == e2c_pkg::ST_SEC || state == e2c_pkg::ST_MIN ||
    state == e2c_pkg::ST_HR || state == e2c_pkg::ST_WDAY)
  `E2C_ASSERT_NOW(a_load_ranges, res_load,
    cal_res.month != 4'd0 && cal_res.month <= 4'd12 && cal_res.day != 5'd0 &&
    hr < 5'd24 && wday < 3'd7)
  `E2C_ASSERT_NEXT(a_load_shows, res_load, res_valid)

endmodule
